// ===== sv/ssr_pkg.sv =====
// Package for the streaming find-and-replace block: sizes, register indexes,
// the queue record type and the length saturation helpers.
// No dependencies.
package ssr_pkg;

    // Longest pattern the window can hold.
    localparam int MAX_PATTERN = 8;
    // Longest replacement, fixed by the 64-bit replacement register.
    localparam int REPL_MAX    = 8;
    // Most words one input byte can cause.
    localparam int RES_MAX     = (MAX_PATTERN > REPL_MAX) ? MAX_PATTERN : REPL_MAX;

    localparam int LEN_W   = 4;
    localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
    localparam int RLEN_W  = $clog2(REPL_MAX + 1);
    localparam int CNT_W   = $clog2(RES_MAX + 1);
    localparam int IDX_W   = $clog2(RES_MAX);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    // One burst of output words caused by one input byte.
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } ssr_rec_t;

    // Pattern length: zero reads as one, large values clip to the window.
    function automatic logic [FILL_W-1:0] sat_plen(input logic [LEN_W-1:0] v);
        logic [FILL_W-1:0] r;
        if (v == '0)
            r = FILL_W'(1);
        else if (int'(v) > MAX_PATTERN)
            r = FILL_W'(MAX_PATTERN);
        else
            r = FILL_W'(v);
        return r;
    endfunction

    // Replacement length clips to the register size.
    function automatic logic [RLEN_W-1:0] sat_rlen(input logic [LEN_W-1:0] v);
        logic [RLEN_W-1:0] r;
        if (int'(v) > REPL_MAX)
            r = RLEN_W'(REPL_MAX);
        else
            r = RLEN_W'(v);
        return r;
    endfunction

endpackage

// ===== sv/ssr_ifs.sv =====
// Channel interfaces of the find-and-replace block: input text, results and
// configuration writes. Depends on ssr_pkg.
interface ssr_in_if import ssr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, data_byte, stream_end, input ready);
    modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface ssr_out_if import ssr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_last;

    modport source (output valid, out_byte, byte_valid, run_last, text_last, input ready);
    modport sink   (input valid, out_byte, byte_valid, run_last, text_last, output ready);
endinterface

interface ssr_cfg_if import ssr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ssr_front.sv =====
// Front of the find-and-replace block: configuration registers, the match
// window and the classifier that turns each input byte into one burst record.
// Depends on ssr_pkg and ssr_ifs.
module ssr_front import ssr_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    ssr_in_if.sink          text,
    ssr_cfg_if.sink         cfg,
    output logic            push_valid,
    input  logic            push_ready,
    output ssr_rec_t        push_rec
);

    logic [MAX_PATTERN-1:0][7:0] pat_reg, pat_next;
    logic [REPL_MAX-1:0][7:0]    repl_reg, repl_next;
    logic [FILL_W-1:0]           plen_reg, plen_next;
    logic [RLEN_W-1:0]           rlen_reg, rlen_next;
    logic [FILL_W-1:0]           fill_reg, fill_next;
    logic [MAX_PATTERN-1:0][7:0] win_reg, win_next;

    logic [MAX_PATTERN-1:0][7:0] win_ins;
    logic [MAX_PATTERN-1:0][7:0] win_sh;
    logic [FILL_W-1:0]           fill_ins;
    logic                        full;
    logic                        eq;
    logic                        accept;
    logic                        cfg_wr;

    assign cfg.ready  = 1'b1;
    assign cfg_wr     = cfg.valid;
    assign text.ready = push_ready;
    assign accept     = text.valid && push_ready;

    // Insert the new byte and compare the window against the pattern.
    always_comb
    begin
        fill_ins = fill_reg + FILL_W'(1);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            win_ins[i] = (FILL_W'(i) == fill_reg) ? text.data_byte : win_reg[i];
        end
        for (int i = 0; i < MAX_PATTERN - 1; i++)
        begin
            win_sh[i] = win_ins[i + 1];
        end
        win_sh[MAX_PATTERN-1] = win_ins[MAX_PATTERN-1];
        eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((FILL_W'(i) < plen_reg) && (win_ins[i] != pat_reg[i]))
                eq = 1'b0;
        end
        full = (fill_ins == plen_reg);
    end

    // Build the burst record and the next window state.
    always_comb
    begin
        push_rec       = '0;
        push_rec.last  = text.stream_end;
        win_next       = win_reg;
        fill_next      = fill_reg;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            push_rec.bytes[i] = win_ins[i];
        end
        if (full && eq)
        begin
            // Match: the replacement goes out and the window empties.
            for (int i = 0; i < RES_MAX; i++)
            begin
                push_rec.bytes[i] = (i < REPL_MAX) ? repl_reg[i] : 8'h00;
            end
            push_rec.cnt = CNT_W'(rlen_reg);
            fill_next    = '0;
        end
        else if (full)
        begin
            // Full without a match: the oldest byte leaves, or all on the end.
            push_rec.cnt = text.stream_end ? CNT_W'(plen_reg) : CNT_W'(1);
            win_next     = win_sh;
            fill_next    = text.stream_end ? '0 : (plen_reg - FILL_W'(1));
        end
        else
        begin
            push_rec.cnt = text.stream_end ? CNT_W'(fill_ins) : '0;
            win_next     = win_ins;
            fill_next    = text.stream_end ? '0 : fill_ins;
        end
        if (!accept)
        begin
            win_next  = win_reg;
            fill_next = fill_reg;
        end
        if (cfg_wr && (cfg.index == REG_PATTERN_LENGTH))
            fill_next = '0;
    end

    // A record goes to the queue when it carries words or ends the text.
    assign push_valid = text.valid && ((push_rec.cnt != '0) || text.stream_end);

    // Configuration register writes.
    always_comb
    begin
        pat_next  = pat_reg;
        repl_next = repl_reg;
        plen_next = plen_reg;
        rlen_next = rlen_reg;
        if (cfg_wr)
        begin
            case (cfg.index)
                REG_PATTERN_BYTES:      pat_next  = cfg.data[8*MAX_PATTERN-1:0];
                REG_PATTERN_LENGTH:     plen_next = sat_plen(cfg.data[LEN_W-1:0]);
                REG_REPLACEMENT_BYTES:  repl_next = cfg.data[8*REPL_MAX-1:0];
                REG_REPLACEMENT_LENGTH: rlen_next = sat_rlen(cfg.data[LEN_W-1:0]);
                default:                ;
            endcase
        end
    end

    // Control and configuration state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg  <= '0;
            repl_reg <= '0;
            plen_reg <= FILL_W'(1);
            rlen_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            pat_reg  <= pat_next;
            repl_reg <= repl_next;
            plen_reg <= plen_next;
            rlen_reg <= rlen_next;
            fill_reg <= fill_next;
        end
    end

    // Window bytes beyond the fill level are never read, so no reset.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    // The window never holds a full pattern between items.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg < plen_reg)
        else $error("window fill reached the pattern length");

endmodule

// ===== sv/ssr_queue.sv =====
// Short record queue between the front and the back of the block.
// Depends on ssr_pkg.
module ssr_queue import ssr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  ssr_rec_t push_rec,
    output logic     pop_valid,
    input  logic     pop,
    output ssr_rec_t pop_rec
);

    ssr_rec_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? (wr_ptr_reg + Q_PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + Q_PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (!do_push && pop)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Record storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_reg != '0)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0])
        else $error("queue pointers disagree with occupancy");

endmodule

// ===== sv/ssr_back.sv =====
// Back of the find-and-replace block: unrolls each burst record into words,
// one per cycle while ready, through the output register. Depends on ssr_pkg and ssr_ifs.
module ssr_back import ssr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop,
    input  ssr_rec_t  pop_rec,
    ssr_out_if.source result
);

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             bvalid_reg, bvalid_next;
    logic             rlast_reg, rlast_next;
    logic             tlast_reg, tlast_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic             load;
    logic             is_final;

    assign load     = !out_valid_reg || result.ready;
    assign is_final = (pop_rec.cnt == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == pop_rec.cnt);
    assign pop      = load && pop_valid && is_final;

    // Pick the next word of the head record.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        bvalid_next    = bvalid_reg;
        rlast_next     = rlast_reg;
        tlast_next     = tlast_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = pop_valid;
            if (pop_valid)
            begin
                bvalid_next = (pop_rec.cnt != '0);
                byte_next   = (pop_rec.cnt != '0) ? pop_rec.bytes[idx_reg] : 8'h00;
                rlast_next  = is_final;
                tlast_next  = is_final && pop_rec.last;
                idx_next    = is_final ? '0 : (idx_reg + IDX_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        rlast_reg  <= rlast_next;
        tlast_reg  <= tlast_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.out_byte   = byte_reg;
    assign result.byte_valid = bvalid_reg;
    assign result.run_last   = rlast_reg;
    assign result.text_last  = tlast_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_rec.cnt != '0) |-> CNT_W'(idx_reg) < pop_rec.cnt)
        else $error("word index ran past the burst length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !bvalid_reg) |-> (tlast_reg && rlast_reg))
        else $error("empty word that does not close the text");

    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> pop_valid)
        else $error("burst in progress without a head record");

endmodule

// ===== sv/stream_substring_replace.sv =====
// Top level of the streaming find-and-replace block.
// Depends on ssr_pkg, ssr_ifs, ssr_front, ssr_queue and ssr_back.
//
// Usage:
//   text   - input words: one text byte each, stream_end set on the last byte.
//   result - output words: out_byte with byte_valid, run_last on the final word
//            caused by one input byte, text_last on the final word of a text.
//            A text that ends with nothing left to send gives one empty word
//            (byte_valid low) carrying run_last and text_last.
//   cfg    - register writes, always ready: 0 pattern bytes, 1 pattern length
//            (clears pending window bytes), 2 replacement bytes,
//            3 replacement length. Write only while the block is idle.
// Timing: an input byte is taken when the record queue has room; its record
// goes through the queue and the output register to its first output word.
// The back end sends one word per cycle while the receiver is ready; a
// four-entry record queue absorbs the bursts while the front takes one byte
// per cycle until the queue fills. Bytes that cause no word pass unqueued.
// Reset: pattern length 1, everything else zero, window and queue empty.
// When the receiver stalls, the output word holds, the queue fills and then
// text.ready drops until a record leaves the queue.
module stream_substring_replace import ssr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ssr_in_if.sink    text,
    ssr_out_if.source result,
    ssr_cfg_if.sink   cfg
);

    logic     push_valid;
    logic     push_ready;
    ssr_rec_t push_rec;
    logic     pop_valid;
    logic     pop;
    ssr_rec_t pop_rec;

    // Window, match and classification.
    ssr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    // Burst records waiting for the back end.
    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_rec    (pop_rec)
    );

    // Word serializer and output register.
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .result    (result)
    );

endmodule

// ===== tb/ssr_replace_checker.sv =====
`timescale 1ns / 1ps
// Checker for the streaming find-and-replace block: tracks register writes,
// predicts the output words of every accepted text word and compares them.
// Depends on ssr_pkg and the channel interfaces in ssr_ifs.
module ssr_replace_checker
    import ssr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ssr_in_if    text,
    ssr_out_if   result,
    ssr_cfg_if   cfg,
    output int   failures,
    output int   pending
);

    // One predicted output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_last;
    } text_word_t;

    // Shadow copy of the registers and of the sliding window.
    logic [63:0]      pattern_word;
    logic [LEN_W-1:0] pattern_len;
    logic [63:0]      subst_word;
    logic [LEN_W-1:0] subst_len;
    logic [7:0]       held_bytes [MAX_PATTERN];
    int unsigned      held_count;

    text_word_t expected_words [$];

    function automatic text_word_t data_word(input logic [7:0] value);
        text_word_t w;
        w = '{out_byte: value, byte_valid: 1'b1, run_last: 1'b0, text_last: 1'b0};
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Works out the words caused by one text byte and queues them.
    task automatic predict_replace(input logic [7:0] value, input logic ends_text);
        text_word_t  burst [$];
        int unsigned match_len;
        int unsigned subst_count;
        logic        hit;

        match_len   = (pattern_len == '0) ? 1 :
                      ((int'(pattern_len) > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len));
        subst_count = (int'(subst_len) > REPL_MAX) ? REPL_MAX : int'(subst_len);

        if (held_count >= match_len)
            held_count = 0;
        held_bytes[held_count] = value;
        held_count++;

        // A full window either matches and turns into the replacement, or
        // gives up its oldest byte.
        if (held_count == match_len) begin
            hit = 1'b1;
            for (int i = 0; i < match_len; i++)
                if (held_bytes[i] != pattern_word[8*i +: 8])
                    hit = 1'b0;
            if (hit) begin
                for (int i = 0; i < subst_count; i++)
                    burst.push_back(data_word(subst_word[8*i +: 8]));
                held_count = 0;
            end
            else begin
                burst.push_back(data_word(held_bytes[0]));
                for (int i = 1; i < MAX_PATTERN; i++)
                    held_bytes[i-1] = held_bytes[i];
                held_count--;
            end
        end

        // The end of a text flushes the window; nothing left gives an empty word.
        if (ends_text) begin
            for (int i = 0; i < held_count; i++)
                burst.push_back(data_word(held_bytes[i]));
            held_count = 0;
            if (burst.size() == 0)
                burst.push_back('{out_byte: 8'h00, byte_valid: 1'b0, run_last: 1'b0,
                                  text_last: 1'b0});
            burst[burst.size()-1].text_last = 1'b1;
        end

        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[i])
            expected_words.push_back(burst[i]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        text_word_t want;
        if (!rst_n) begin
            pattern_word = '0;
            pattern_len  = LEN_W'(1);
            subst_word   = '0;
            subst_len    = '0;
            foreach (held_bytes[i])
                held_bytes[i] = 8'h00;
            held_count = 0;
            expected_words.delete();
            pending = 0;
        end
        else begin
            // Compare a delivered word with the oldest prediction.
            if (result.valid && result.ready) begin
                if (expected_words.size() == 0) begin
                    $error("out_byte %0h (byte_valid %0b) arrived with no word expected",
                           result.out_byte, result.byte_valid);
                    failures++;
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("out_byte", want.out_byte, result.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid), 8'(result.byte_valid));
                    check_field("run_last", 8'(want.run_last), 8'(result.run_last));
                    check_field("text_last", 8'(want.text_last), 8'(result.text_last));
                end
            end

            if (text.valid && text.ready)
                predict_replace(text.data_byte, text.stream_end);

            // Register writes; a new pattern length drops the pending bytes.
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_PATTERN_BYTES:      pattern_word = cfg.data;
                    REG_PATTERN_LENGTH:
                    begin
                        pattern_len = cfg.data[LEN_W-1:0];
                        held_count  = 0;
                    end
                    REG_REPLACEMENT_BYTES:  subst_word = cfg.data;
                    REG_REPLACEMENT_LENGTH: subst_len = cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end

            pending = expected_words.size();
        end
    end

endmodule

// ===== tb/stream_substring_replace_test.sv =====
`timescale 1ns / 1ps
// Testbench top for stream_substring_replace: clock, reset, text stimulus,
// register writes, result backpressure, watchdog and the verdict.
// Depends on ssr_pkg, ssr_ifs, the block itself and ssr_replace_checker.
module stream_substring_replace_test;
    import ssr_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 33;
    localparam int HOLD_CYCLES   = 90;
    localparam int IDLE_PERCENT  = 22;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          words_due;
    int          idle_cycles;
    bit          calm;
    bit          long_hold_go;
    logic [63:0] cur_pattern;
    int unsigned cur_plen;
    int unsigned bytes_sent;

    ssr_in_if  text_ch();
    ssr_out_if result_ch();
    ssr_cfg_if cfg_ch();

    stream_substring_replace uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ssr_replace_checker check (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .result   (result_ch),
        .cfg      (cfg_ch),
        .failures (fail_count),
        .pending  (words_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Watchdog: any accepted word on any channel restarts the count.
    wire moved = (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready);

    always @(posedge clk)
    begin
        if (!rst_n || moved)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** stream_substring_replace: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result receiver: random stalls, one long hold-off on request, none when calm.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offers one text word, with a random gap unless calm; returns at a falling edge.
    task automatic send_byte(input logic [7:0] value, input logic ends_text);
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.data_byte  <= value;
        text_ch.stream_end <= ends_text;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic text_idle();
        text_ch.valid <= 1'b0;
    endtask

    // Waits until every predicted word has arrived and the pipeline has drained.
    task automatic wait_idle();
        while (words_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [63:0] pat, input logic [LEN_W-1:0] plen,
                                 input logic [63:0] subst, input logic [LEN_W-1:0] slen);
        wait_idle();
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH, 64'(plen));
        write_reg(REG_REPLACEMENT_BYTES, subst);
        write_reg(REG_REPLACEMENT_LENGTH, 64'(slen));
        cur_pattern = pat;
        cur_plen    = (plen == '0) ? 1 : ((int'(plen) > MAX_PATTERN) ? MAX_PATTERN : int'(plen));
    endtask

    // Builds a text mostly from whole and partial copies of the pattern, with
    // some noise, and sends it with stream_end on its final byte.
    task automatic send_random_text(input int unsigned n_bytes);
        logic [7:0]  body [$];
        int unsigned cut;
        while (body.size() < n_bytes)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    for (int j = 0; j < cur_plen; j++)
                        body.push_back(cur_pattern[8*j +: 8]);
                end
                6, 7:
                begin
                    cut = $urandom_range(cur_plen);
                    for (int j = 0; j < cut; j++)
                        body.push_back(cur_pattern[8*j +: 8]);
                end
                8:
                    body.push_back(8'($urandom_range(255)));
                default:
                begin
                    cut = $urandom_range(cur_plen - 1);
                    body.push_back(cur_pattern[8*cut +: 8]);
                end
            endcase
        end
        foreach (body[i])
            send_byte(body[i], i == body.size() - 1);
    endtask

    // Main stimulus.
    initial
    begin
        logic [63:0]      pb;
        logic [63:0]      rb;
        logic [LEN_W-1:0] pl;
        logic [LEN_W-1:0] rl;
        int unsigned      pick;
        int unsigned      phase_start;

        rst_n              = 1'b0;
        calm               = 1'b0;
        long_hold_go       = 1'b0;
        bytes_sent         = 0;
        cur_pattern        = '0;
        cur_plen           = 1;
        text_ch.valid      = 1'b0;
        text_ch.data_byte  = 8'h00;
        text_ch.stream_end = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_PATTERN_BYTES;
        cfg_ch.data        = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: a zero byte is deleted, so the final zero leaves an
        // empty end word; the deleted first byte gives no word at all.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        text_idle();

        // Two-byte pattern, longer replacement, overlapping candidates.
        apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("x", 1'b0);
        send_byte("a", 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte("a", 1'b1);
        text_idle();

        // Zero pattern length reads as one; replacement length clips to eight.
        apply_setting(64'h41, 4'd0, 64'h0123456789ABCDEF, 4'd15);
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b1);
        text_idle();

        // Pattern length clips to the window; a match completes on the last byte.
        apply_setting(64'hF0E1D2C3B4A59687, 4'd15, 64'h00FF00FF00FF00FF, 4'd8);
        send_byte(8'hFF, 1'b0);
        for (int j = 0; j < MAX_PATTERN; j++)
            send_byte(cur_pattern[8*j +: 8], j == MAX_PATTERN - 1);
        text_idle();

        // Rewriting the pattern length in mid-text drops the pending bytes,
        // so the rest of the pattern no longer matches.
        apply_setting(64'h7A797877, 4'd4, 64'h21, 4'd1);
        send_byte("w", 1'b0);
        send_byte("x", 1'b0);
        text_idle();
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd4);
        send_byte("y", 1'b0);
        send_byte("z", 1'b1);
        text_idle();

        // Random phases, each with a fresh setting; the first two are extremes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            pb   = {$urandom, $urandom};
            rb   = {$urandom, $urandom};
            pick = $urandom_range(9);
            pl   = (pick == 0) ? 4'd0 :
                   ((pick == 1) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(5, 1)));
            rl   = 4'($urandom_range(15));
            if (ph == 0)
            begin
                pb = '1;
                pl = 4'd8;
                rb = '0;
                rl = 4'd8;
            end
            if (ph == 1)
            begin
                pb = '0;
                pl = 4'd1;
                rb = '1;
                rl = 4'd0;
            end
            apply_setting(pb, pl, rb, rl);
            calm <= (ph == 2);
            if (ph == 4)
                long_hold_go <= 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_text($urandom_range(24, 1));
            text_idle();
        end

        while (words_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && words_due == 0)
            $display("** stream_substring_replace: PASSED **");
        else
            $display("** stream_substring_replace: FAILED **");
        $finish;
    end

endmodule
